// ----- hw/rtl/jsu_pkg.sv -----
// jsu_pkg: shared types and codes for the JSON string unescape core.
// Used by jsu_front, jsu_queue, jsu_back and the top level.
`timescale 1ns / 1ps

package jsu_pkg;

  // Parser phase
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_STR     = 4'd1,
    PH_ESC     = 4'd2,
    PH_HEX1    = 4'd3,
    PH_WANT_BS = 4'd4,
    PH_WANT_U  = 4'd5,
    PH_HEX2    = 4'd6
  } phase_t;

  // Result kind as seen on the output tuser
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // Closing result of one command, after its data bytes
  typedef enum logic [1:0] {
    TAIL_NONE  = 2'd0,
    TAIL_DONE  = 2'd1,
    TAIL_ERROR = 2'd2
  } tail_t;

  // Error codes
  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_CTRL      = 4'd1;
  localparam logic [3:0] ERR_ESCAPE    = 4'd2;
  localparam logic [3:0] ERR_HEX       = 4'd3;
  localparam logic [3:0] ERR_LONE_LOW  = 4'd4;
  localparam logic [3:0] ERR_NO_LOW    = 4'd5;
  localparam logic [3:0] ERR_LOW_RANGE = 4'd6;
  localparam logic [3:0] ERR_TEXT_END  = 4'd7;
  localparam logic [3:0] ERR_NO_QUOTE  = 4'd8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One classified input byte: up to four data bytes and an optional tail
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n_data;
    tail_t           tail;
    logic [3:0]      err;
  } cmd_t;

endpackage

// ----- hw/rtl/json_string_unescape_utf8_core.sv -----
// json_string_unescape_utf8_core: top level of the JSON string unescape core.
// Instantiates jsu_front, jsu_queue and jsu_back; depends on jsu_pkg.
//
//  channel | dir | tdata                    | tuser | tlast
//  s_*     | in  | [7:0] ch                 | -     | final_req
//  m_*     | out | [7:0] data_byte, [11:8] error_code | kind | last_of_run
//
// A text byte is taken every cycle while the 4-entry command queue has room.
// The back end sends one result word per cycle unless the output stalls; a
// byte that yields results gives 1 to 5 words, through queue and output stage.
// Reset clears the phase, queue and output stage; no clearing pass.
// Output stalls back up into the queue and then onto s_tready.
`timescale 1ns / 1ps

module json_string_unescape_utf8_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] data_byte, [11:8] error_code, [15:12] zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast
);
  import jsu_pkg::*;

  logic accept;
  logic push;
  logic full;
  logic q_valid;
  logic q_pop;
  cmd_t cmd;
  cmd_t q_head;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  jsu_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .ch     (s_tdata),
    .fin    (s_tlast),
    .push   (push),
    .cmd    (cmd)
  );

  jsu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (cmd),
    .full     (full),
    .valid    (q_valid),
    .head     (q_head),
    .pop      (q_pop)
  );

  jsu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- hw/rtl/jsu_front.sv -----
// jsu_front: accepts text bytes, tracks string/escape/hex phase and builds
// one command per byte that yields results. Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_front (
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic [7:0]   ch,
  input  logic         fin,
  output logic         push,
  output jsu_pkg::cmd_t cmd
);
  import jsu_pkg::*;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } utf8_t;

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t r;
    r.b = '0;
    if (cp < 21'h80) begin
      r.b[0] = cp[7:0];
      r.n = 3'd1;
    end else if (cp < 21'h800) begin
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
      r.n = 3'd2;
    end else if (cp < 21'h10000) begin
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
      r.n = 3'd3;
    end else begin
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
      r.n = 3'd4;
    end
    return r;
  endfunction

  phase_t      phase, phase_next;
  logic [15:0] code_unit, code_unit_next;
  logic [1:0]  digit_count, digit_count_next;
  logic [9:0]  high_bits, high_bits_next;

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] cu_shift;
  logic        last_digit;
  logic        is_high, is_low;
  logic        done;
  logic [3:0]  err;
  logic [20:0] cp;
  utf8_t       enc;

  // Hex digit decode
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (ch >= "0" && ch <= "9") begin
      hex_val = 4'(ch - "0");
    end else if (ch >= "a" && ch <= "f") begin
      hex_val = 4'(ch - "a" + 8'd10);
    end else if (ch >= "A" && ch <= "F") begin
      hex_val = 4'(ch - "A" + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cu_shift   = {code_unit[11:0], hex_val};
  assign last_digit = (digit_count == 2'd3);
  assign is_high    = (cu_shift >= 16'hD800) && (cu_shift <= 16'hDBFF);
  assign is_low     = (cu_shift >= 16'hDC00) && (cu_shift <= 16'hDFFF);

  // Classify: done and error code for this byte
  always_comb begin
    done = 1'b0;
    err  = ERR_NONE;
    unique case (phase)
      PH_STR: begin
        if (ch == "\"") done = 1'b1;
        else if (ch != "\\" && ch < 8'h20) err = ERR_CTRL;
      end
      PH_ESC: begin
        case (ch)
          "\"", "\\", "/", "b", "f", "n", "r", "t", "u": ;
          default: err = ERR_ESCAPE;
        endcase
      end
      PH_HEX1: begin
        if (!hex_ok) err = ERR_HEX;
        else if (last_digit && is_low) err = ERR_LONE_LOW;
      end
      PH_HEX2: begin
        if (!hex_ok) err = ERR_HEX;
        else if (last_digit && !is_low) err = ERR_LOW_RANGE;
      end
      PH_WANT_BS: if (ch != "\\") err = ERR_NO_LOW;
      PH_WANT_U:  if (ch != "u") err = ERR_NO_LOW;
      default: begin
        if (ch != "\"" && ch != " " && ch != 8'h09 && ch != 8'h0A && ch != 8'h0D)
          err = ERR_NO_QUOTE;
      end
    endcase
  end

  // Next state
  always_comb begin
    phase_next       = phase;
    code_unit_next   = code_unit;
    digit_count_next = digit_count;
    high_bits_next   = high_bits;
    unique case (phase)
      PH_STR: if (ch == "\\") phase_next = PH_ESC;
      PH_ESC: begin
        if (ch == "u") begin
          phase_next       = PH_HEX1;
          code_unit_next   = '0;
          digit_count_next = '0;
        end else begin
          phase_next = PH_STR;
        end
      end
      PH_HEX1, PH_HEX2: begin
        if (!last_digit) begin
          code_unit_next   = cu_shift;
          digit_count_next = 2'(digit_count + 2'd1);
        end else begin
          code_unit_next   = '0;
          digit_count_next = '0;
          if (phase == PH_HEX1 && is_high) begin
            high_bits_next = cu_shift[9:0];
            phase_next     = PH_WANT_BS;
          end else begin
            phase_next = PH_STR;
          end
        end
      end
      PH_WANT_BS: if (ch == "\\") phase_next = PH_WANT_U;
      PH_WANT_U: begin
        if (ch == "u") begin
          phase_next       = PH_HEX2;
          code_unit_next   = '0;
          digit_count_next = '0;
        end
      end
      default: if (ch == "\"") phase_next = PH_STR;
    endcase
    // done, any error or end of text returns to reset state
    if (done || err != ERR_NONE || fin) begin
      phase_next       = PH_IDLE;
      code_unit_next   = '0;
      digit_count_next = '0;
      high_bits_next   = '0;
    end
  end

  // Code point of a finished \u escape
  assign cp  = (phase == PH_HEX2) ? 21'h10000 + {1'b0, high_bits, cu_shift[9:0]}
                                  : {5'd0, cu_shift};
  assign enc = utf8_enc(cp);

  // Outputs: command for the back end
  always_comb begin
    cmd        = '0;
    cmd.tail   = TAIL_NONE;
    cmd.err    = ERR_NONE;
    if (err == ERR_NONE && !done) begin
      unique case (phase)
        PH_STR: begin
          if (ch != "\\") begin
            cmd.bytes[0] = ch;
            cmd.n_data   = 3'd1;
          end
        end
        PH_ESC: begin
          cmd.n_data = 3'd1;
          case (ch)
            "b":     cmd.bytes[0] = 8'h08;
            "f":     cmd.bytes[0] = 8'h0C;
            "n":     cmd.bytes[0] = 8'h0A;
            "r":     cmd.bytes[0] = 8'h0D;
            "t":     cmd.bytes[0] = 8'h09;
            "u":     cmd.n_data   = 3'd0;
            default: cmd.bytes[0] = ch;
          endcase
        end
        PH_HEX1, PH_HEX2: begin
          if (last_digit && !(phase == PH_HEX1 && is_high)) begin
            cmd.bytes  = enc.b;
            cmd.n_data = enc.n;
          end
        end
        default: ;
      endcase
    end
    if (done) begin
      cmd.tail = TAIL_DONE;
    end else if (err != ERR_NONE) begin
      cmd.tail = TAIL_ERROR;
      cmd.err  = err;
    end else if (fin) begin
      cmd.tail = TAIL_ERROR;
      cmd.err  = ERR_TEXT_END;
    end
  end

  assign push = accept && (cmd.n_data != 3'd0 || cmd.tail != TAIL_NONE);

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      code_unit   <= '0;
      digit_count <= '0;
      high_bits   <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      code_unit   <= code_unit_next;
      digit_count <= digit_count_next;
      high_bits   <= high_bits_next;
    end
  end

  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    accept && fin |=> phase == PH_IDLE && digit_count == 2'd0)
    else $error("front not idle after final byte");

  a_tail_once: assert property (@(posedge clk) disable iff (rst)
    push && cmd.tail == TAIL_NONE |-> !fin)
    else $error("final byte pushed without closing result");

endmodule

// ----- hw/rtl/jsu_queue.sv -----
// jsu_queue: small register FIFO of commands between front and back end.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jsu_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          valid,
  output jsu_pkg::cmd_t head,
  input  logic          pop
);
  import jsu_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  // Slot storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= QPTR_W'(wr_ptr + 1'b1);
      if (pop)  rd_ptr <= QPTR_W'(rd_ptr + 1'b1);
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !valid |-> !pop)
    else $error("pop from empty queue");

endmodule

// ----- hw/rtl/jsu_back.sv -----
// jsu_back: expands queued commands into result words, one per cycle while
// the output is not stalled, through a registered output stage. Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  jsu_pkg::cmd_t q_head,
  output logic          q_pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [15:0]   m_tdata,   // [7:0] data_byte, [11:8] error_code, [15:12] zero
  output logic [1:0]    m_tuser,   // [1:0] kind
  output logic          m_tlast    // last_of_run
);
  import jsu_pkg::*;

  logic [2:0] idx;
  logic [2:0] total;
  logic       load;
  logic       is_last;
  logic       is_data;

  assign total   = q_head.n_data + 3'(q_head.tail != TAIL_NONE);
  assign load    = q_valid && (!m_tvalid || m_tready);
  assign is_last = (idx == 3'(total - 3'd1));
  assign is_data = (idx < q_head.n_data);
  assign q_pop   = load && is_last;

  // Word index within the head command
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= is_last ? 3'd0 : 3'(idx + 3'd1);
    end
  end

  // Output stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output stage payload
  always_ff @(posedge clk) begin
    if (load) begin
      m_tlast <= is_last;
      if (is_data) begin
        m_tdata <= {8'h00, q_head.bytes[idx[1:0]]};
        m_tuser <= KIND_DATA;
      end else if (q_head.tail == TAIL_DONE) begin
        m_tdata <= '0;
        m_tuser <= KIND_DONE;
      end else begin
        m_tdata <= {4'h0, q_head.err, 8'h00};
        m_tuser <= KIND_ERROR;
      end
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> idx < total)
    else $error("word index beyond command");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word dropped while stalled");

endmodule
